// ----- design/dwq_pkg.sv -----
`timescale 1ns / 1ps
// Package for the deduplicating work queue.
// Holds the request and response types, status codes and fixed field widths.
package dwq_pkg;

  localparam int unsigned COORD_BITS = 16;
  localparam int unsigned PAIR_BITS  = 2 * COORD_BITS;
  localparam int unsigned OCC_W      = 10;

  typedef enum logic {
    FUNC_PUSH = 1'b0,
    FUNC_POP  = 1'b1
  } func_e;

  typedef enum logic [2:0] {
    ST_QUEUED    = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_POPPED    = 3'd3,
    ST_EMPTY     = 3'd4
  } status_e;

  typedef struct packed {
    func_e                         func;
    logic signed [COORD_BITS-1:0]  coord_x;
    logic signed [COORD_BITS-1:0]  coord_z;
  } in_req_t;

  typedef struct packed {
    status_e                       status;
    logic signed [COORD_BITS-1:0]  out_x;
    logic signed [COORD_BITS-1:0]  out_z;
    logic        [OCC_W-1:0]       occupancy;
  } out_rsp_t;

endpackage

// ----- design/dwq_mem.sv -----
`timescale 1ns / 1ps
// Entry store of the work queue: one write port and one registered read port.
// Stand-alone; sized by its depth and word width parameters.
module dwq_mem #(
  parameter int unsigned DEPTH  = 512,
  parameter int unsigned DATA_W = 32,
  localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/dwq_ctrl.sv -----
`timescale 1ns / 1ps
// Sequencer of the work queue: head and count registers, the duplicate scan
// with its shared pair comparator, and result forming. Uses dwq_pkg.
module dwq_ctrl #(
  parameter int unsigned QUEUE_DEPTH = 512,
  localparam int unsigned IDX_W = $clog2(QUEUE_DEPTH),
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  dwq_pkg::in_req_t         in_req_i,
  input  logic                     res_ready_i,
  output logic                     res_valid_o,
  output dwq_pkg::out_rsp_t        res_o,
  output logic                     mem_we_o,
  output logic [IDX_W-1:0]         mem_waddr_o,
  output logic [dwq_pkg::PAIR_BITS-1:0] mem_wdata_o,
  output logic [IDX_W-1:0]         mem_raddr_o,
  input  logic [dwq_pkg::PAIR_BITS-1:0] mem_rdata_i
);
  import dwq_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_POP  = 4'b0100,
    S_DONE = 4'b1000
  } state_e;

  function automatic logic [IDX_W-1:0] wrap_add(logic [IDX_W-1:0] base,
                                                logic [CNT_W-1:0] off);
    logic [IDX_W+1:0] sum;
    sum = (IDX_W+2)'(base) + (IDX_W+2)'(off);
    if (sum >= (IDX_W+2)'(QUEUE_DEPTH)) begin
      sum = sum - (IDX_W+2)'(QUEUE_DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

  state_e                       state_q, state_d;
  logic [IDX_W-1:0]             head_q, head_d;
  logic [CNT_W-1:0]             count_q, count_d;
  logic [CNT_W-1:0]             idx_q, idx_d;
  logic                         rd_vld_q, rd_vld_d;
  logic signed [COORD_BITS-1:0] x_q, x_d;
  logic signed [COORD_BITS-1:0] z_q, z_d;
  out_rsp_t                     res_q, res_d;
  logic                         match;

  assign match = rd_vld_q && (mem_rdata_i == {x_q, z_q});

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    count_d     = count_q;
    idx_d       = idx_q;
    rd_vld_d    = rd_vld_q;
    x_d         = x_q;
    z_d         = z_q;
    res_d       = res_q;
    mem_we_o    = 1'b0;
    mem_raddr_o = wrap_add(head_q, idx_q);
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          x_d      = in_req_i.coord_x;
          z_d      = in_req_i.coord_z;
          idx_d    = '0;
          rd_vld_d = 1'b0;
          if (in_req_i.func == FUNC_POP) begin
            mem_raddr_o = head_q;
            if (count_q == '0) begin
              res_d   = '{ST_EMPTY, '0, '0, OCC_W'(count_q)};
              state_d = S_DONE;
            end else begin
              state_d = S_POP;
            end
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (match) begin
          res_d   = '{ST_DUPLICATE, '0, '0, OCC_W'(count_q)};
          state_d = S_DONE;
        end else if (idx_q != count_q) begin
          rd_vld_d = 1'b1;
          idx_d    = idx_q + CNT_W'(1);
        end else if (rd_vld_q) begin
          rd_vld_d = 1'b0;
        end else begin
          if (count_q == CNT_W'(QUEUE_DEPTH)) begin
            res_d = '{ST_FULL, x_q, z_q, OCC_W'(count_q)};
          end else begin
            mem_we_o = 1'b1;
            count_d  = count_q + CNT_W'(1);
            res_d    = '{ST_QUEUED, '0, '0, OCC_W'(count_q + CNT_W'(1))};
          end
          state_d = S_DONE;
        end
      end
      S_POP: begin
        head_d  = wrap_add(head_q, CNT_W'(1));
        count_d = count_q - CNT_W'(1);
        res_d   = '{ST_POPPED, mem_rdata_i[PAIR_BITS-1:COORD_BITS],
                    mem_rdata_i[COORD_BITS-1:0], OCC_W'(count_q - CNT_W'(1))};
        state_d = S_DONE;
      end
      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      head_q   <= '0;
      count_q  <= '0;
      idx_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      head_q   <= head_d;
      count_q  <= count_d;
      idx_q    <= idx_d;
      rd_vld_q <= rd_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    z_q   <= z_d;
    res_q <= res_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign res_valid_o = (state_q == S_DONE);
  assign res_o       = res_q;
  assign mem_waddr_o = wrap_add(head_q, count_q);
  assign mem_wdata_o = {x_q, z_q};

endmodule

// ----- design/dedup_work_queue_core.sv -----
`timescale 1ns / 1ps
// Top level of the deduplicating work queue: sequencer, entry store and
// output register. Uses dwq_pkg, dwq_ctrl and dwq_mem.
//
// A request on the input channel either pushes a coordinate pair or pops the
// head entry. A push is compared against every queued entry, one entry per
// cycle through a single comparator fed by the store's read port; a duplicate
// is dropped, a push into a full queue is echoed back with a full status, and
// otherwise the pair is appended at the tail. A pop returns the head entry or
// an empty status. Every request gives one response carrying the occupancy.
// A push's response is ready once the scan has passed every queued entry, or
// earlier when a duplicate is found; a pop first reads the head entry from
// the store, while an empty pop answers without a read of the store.
// Only one request is in work at a time; in_stall_o is high
// until its response has moved to the output register, which lets the next
// request in while the previous response still waits there.
// When the receiver stalls, the response holds in the output register and
// at most one more finished response waits inside the sequencer.
// Reset empties the queue at once; the entry store needs no clearing.
module dedup_work_queue_core #(
  parameter int unsigned QUEUE_DEPTH = 512
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  dwq_pkg::in_req_t   in_req_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output dwq_pkg::out_rsp_t  out_rsp_o
);
  import dwq_pkg::*;

  localparam int unsigned IDX_W = $clog2(QUEUE_DEPTH);

  logic                 res_ready;
  logic                 res_valid;
  out_rsp_t             res;
  logic                 mem_we;
  logic [IDX_W-1:0]     mem_waddr;
  logic [IDX_W-1:0]     mem_raddr;
  logic [PAIR_BITS-1:0] mem_wdata;
  logic [PAIR_BITS-1:0] mem_rdata;
  logic                 out_vld_q, out_vld_d;
  out_rsp_t             out_rsp_q;

  dwq_ctrl #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .res_ready_i(res_ready),
    .res_valid_o(res_valid),
    .res_o      (res),
    .mem_we_o   (mem_we),
    .mem_waddr_o(mem_waddr),
    .mem_wdata_o(mem_wdata),
    .mem_raddr_o(mem_raddr),
    .mem_rdata_i(mem_rdata)
  );

  dwq_mem #(
    .DEPTH (QUEUE_DEPTH),
    .DATA_W(PAIR_BITS)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  assign res_ready = !out_vld_q || !out_stall_i;

  always_comb begin
    out_vld_d = out_vld_q;
    if (res_ready) begin
      out_vld_d = res_valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_rsp_q <= res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_rsp_o   = out_rsp_q;

endmodule
